/* hw/rtl/utl_pkg.sv */
// Types, constants and decode functions shared by the UTF-8 to Latin-1 transcoder.
package utl_pkg;

  localparam logic [7:0]  REPL_RESET = 8'h5F;

  localparam logic [30:0] CP_LDQUO = 31'h0000_201C;
  localparam logic [30:0] CP_RDQUO = 31'h0000_201D;
  localparam logic [30:0] CP_RSQUO = 31'h0000_2019;
  localparam logic [30:0] CP_EURO  = 31'h0000_20AC;
  localparam logic [30:0] CP_MAX   = 31'h0000_00FF;

  localparam logic [7:0]  LAT_LDQUO = 8'h93;
  localparam logic [7:0]  LAT_RDQUO = 8'h94;
  localparam logic [7:0]  LAT_RSQUO = 8'h92;
  localparam logic [7:0]  LAT_EURO  = 8'hA4;

  localparam logic [1:0]  CONT_TAG = 2'b10;

  typedef struct packed {
    logic [2:0] rem;
    logic [6:0] init;
    logic       three;
  } utl_lead_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
  } utl_entry_t;

  function automatic utl_lead_t lead_decode(input logic [7:0] b);
    utl_lead_t r;
    r.three = 1'b0;
    if (b < 8'h80) begin
      r.rem  = 3'd0;
      r.init = b[6:0];
    end else if (b < 8'hC0) begin
      r.rem  = 3'd4;
      r.init = {1'b0, b[5:0]};
    end else if (b < 8'hE0) begin
      r.rem  = 3'd1;
      r.init = {2'b00, b[4:0]};
    end else if (b < 8'hF0) begin
      r.rem   = 3'd2;
      r.init  = {3'b000, b[3:0]};
      r.three = 1'b1;
    end else if (b < 8'hF8) begin
      r.rem  = 3'd3;
      r.init = {4'b0000, b[2:0]};
    end else if (b < 8'hFC) begin
      r.rem  = 3'd4;
      r.init = {5'b00000, b[1:0]};
    end else begin
      r.rem  = 3'd5;
      r.init = {6'b000000, b[0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] map_code(input logic [30:0] v, input logic three,
                                          input logic [7:0] repl);
    logic [7:0] r;
    if (three && v == CP_LDQUO) begin
      r = LAT_LDQUO;
    end else if (three && v == CP_RDQUO) begin
      r = LAT_RDQUO;
    end else if (three && v == CP_RSQUO) begin
      r = LAT_RSQUO;
    end else if (three && v == CP_EURO) begin
      r = LAT_EURO;
    end else if (v <= CP_MAX) begin
      r = v[7:0];
    end else begin
      r = repl;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/utl_ifs.sv */
// Channel interfaces for UTF-8 input, Latin-1 output and the configuration write.
interface utl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       string_end;
  modport source(output valid, utf8_byte, string_end, input ready);
  modport sink(input valid, utf8_byte, string_end, output ready);
endinterface

interface utl_latin_if;
  logic       valid;
  logic       ready;
  logic [7:0] latin_byte;
  logic       run_last;
  modport source(output valid, latin_byte, run_last, input ready);
  modport sink(input valid, latin_byte, run_last, output ready);
endinterface

interface utl_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] replacement_byte;
  modport source(output valid, replacement_byte, input ready);
  modport sink(input valid, replacement_byte, output ready);
endinterface

/* hw/rtl/utl_front.sv */
// Front end: accepts UTF-8 bytes, tracks the pending sequence and forms result entries.
module utl_front (
  input  logic              clk,
  input  logic              rst,
  utl_byte_if.sink          src,
  utl_cfg_if.sink           cfg,
  input  logic              full,
  output logic              push,
  output utl_pkg::utl_entry_t entry
);
  import utl_pkg::*;

  logic [30:0] accum;
  logic [30:0] accum_next;
  logic [2:0]  rem;
  logic [2:0]  rem_next;
  logic        three;
  logic        three_next;
  logic [7:0]  repl;

  logic        accept;
  logic        is_cont;
  logic [30:0] v_cont;
  logic [2:0]  rem_dec;
  utl_lead_t   lead;
  logic        emit_p;
  logic        emit_s;
  logic [7:0]  p_byte;
  logic [7:0]  s_byte;

  assign src.ready = !full;
  assign cfg.ready = 1'b1;
  assign accept    = src.valid && src.ready;
  assign is_cont   = src.utf8_byte[7:6] == CONT_TAG;
  assign v_cont    = {accum[24:0], src.utf8_byte[5:0]};
  assign rem_dec   = rem - 3'd1;
  assign lead      = lead_decode(src.utf8_byte);
  assign p_byte    = map_code(accum, three, repl);

  always_comb begin
    accum_next = accum;
    rem_next   = rem;
    three_next = three;
    emit_p     = 1'b0;
    emit_s     = 1'b0;
    s_byte     = map_code(v_cont, three, repl);
    if (rem != 3'd0 && is_cont) begin
      accum_next = v_cont;
      rem_next   = rem_dec;
      if (rem_dec == 3'd0 || src.string_end) begin
        emit_s = 1'b1;
      end
    end else begin
      emit_p     = rem != 3'd0;
      accum_next = {24'd0, lead.init};
      rem_next   = lead.rem;
      three_next = lead.three;
      s_byte     = map_code({24'd0, lead.init}, lead.three, repl);
      if (lead.rem == 3'd0 || src.string_end) begin
        emit_s = 1'b1;
      end
    end
    if (emit_s) begin
      accum_next = '0;
      rem_next   = 3'd0;
      three_next = 1'b0;
    end
  end

  assign push        = accept && (emit_p || emit_s);
  assign entry.byte0 = emit_p ? p_byte : s_byte;
  assign entry.byte1 = s_byte;
  assign entry.two   = emit_p && emit_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      rem   <= 3'd0;
      three <= 1'b0;
      repl  <= REPL_RESET;
    end else begin
      if (accept) begin
        accum <= accum_next;
        rem   <= rem_next;
        three <= three_next;
      end
      if (cfg.valid && cfg.ready) begin
        repl <= cfg.replacement_byte;
      end
    end
  end

  // No sequence is ever longer than six bytes.
  a_rem_range: assert property (@(posedge clk) disable iff (rst) rem <= 3'd5)
    else $error("pending count out of range");

endmodule

/* hw/rtl/utl_fifo.sv */
// Short queue of result entries between the front end and the back end.
module utl_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utl_pkg::utl_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output utl_pkg::utl_entry_t head,
  output logic                nonempty
);
  import utl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utl_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("pop from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

/* hw/rtl/utl_back.sv */
// Back end: holds one entry and delivers its one or two Latin-1 bytes in order.
module utl_back (
  input  logic                clk,
  input  logic                rst,
  input  utl_pkg::utl_entry_t head,
  input  logic                nonempty,
  output logic                pop,
  utl_latin_if.source         dst
);
  import utl_pkg::*;

  utl_entry_t cur;
  logic       cur_valid;
  logic       phase;
  logic       fire;
  logic       done;
  logic       can_load;

  assign fire     = dst.valid && dst.ready;
  assign done     = fire && (phase || !cur.two);
  assign can_load = !cur_valid || done;
  assign pop      = can_load && nonempty;

  assign dst.valid      = cur_valid;
  assign dst.latin_byte = phase ? cur.byte1 : cur.byte0;
  assign dst.run_last   = phase || !cur.two;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (can_load) begin
        cur_valid <= nonempty;
        phase     <= 1'b0;
      end else if (fire) begin
        phase <= 1'b1;
      end
    end
  end

  // The second byte is only ever shown for a held entry that carries two.
  a_phase_two: assert property (@(posedge clk) disable iff (rst) phase |-> (cur_valid && cur.two))
    else $error("second byte selected without a two-byte entry");

endmodule

/* hw/rtl/utf8_to_latin1_transcoder_unit.sv */
// Top level of the UTF-8 to Latin-1 transcoder.
// The block takes one UTF-8 byte per clock while its queue has room and returns zero, one or
// two Latin-1 bytes for it; run_last marks the last byte caused by each input request. A byte
// that breaks a pending sequence flushes the partial character and then starts its own, which
// yields two outputs when the new byte completes a character alone or ends the string. Code
// points above 0xFF give the configured replacement byte, except the curly quotes and the euro
// sign reached from a three-byte lead, which map to the fixed bytes 0x93, 0x94, 0x92 and 0xA4.
// Input is taken every cycle while the result queue (QUEUE_DEPTH entries) has room; the output
// stage delivers one byte per cycle while the receiver is ready, so an input that yields two
// bytes occupies it for both and sustained throughput is one input per cycle for single-result
// streams. The replacement byte resets to 0x5F and is written through the configuration
// channel; the user must do so only while the block is idle, which the block does not enforce.
module utf8_to_latin1_transcoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  utl_byte_if.sink     utf8_chan,
  utl_cfg_if.sink      cfg_chan,
  utl_latin_if.source  latin_chan
);
  import utl_pkg::*;

  utl_entry_t push_entry;
  utl_entry_t head;
  logic       push;
  logic       pop;
  logic       full;
  logic       nonempty;

  utl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .src   (utf8_chan),
    .cfg   (cfg_chan),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  utl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .nonempty   (nonempty)
  );

  utl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .dst      (latin_chan)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the UTF-8 to Latin-1 transcoder with a byte-level decode predictor.
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] latin_byte;
  logic       run_last;
} latin_res_t;

class latin_board;
  logic [30:0] code_acc;
  logic [2:0]  bytes_left;
  logic        three_lead;
  logic [7:0]  repl_byte;
  latin_res_t  expected_latin[$];
  int          mismatches;

  function new();
    code_acc   = '0;
    bytes_left = '0;
    three_lead = 1'b0;
    repl_byte  = utl_pkg::REPL_RESET;
    mismatches = 0;
  endfunction

  function logic [7:0] map_point();
    if (three_lead && code_acc == utl_pkg::CP_LDQUO) return utl_pkg::LAT_LDQUO;
    if (three_lead && code_acc == utl_pkg::CP_RDQUO) return utl_pkg::LAT_RDQUO;
    if (three_lead && code_acc == utl_pkg::CP_RSQUO) return utl_pkg::LAT_RSQUO;
    if (three_lead && code_acc == utl_pkg::CP_EURO) return utl_pkg::LAT_EURO;
    if (code_acc <= utl_pkg::CP_MAX) return code_acc[7:0];
    return repl_byte;
  endfunction

  function void flush_char();
    latin_res_t r;
    r.latin_byte = map_point();
    r.run_last   = 1'b0;
    expected_latin.push_back(r);
    code_acc   = '0;
    bytes_left = '0;
    three_lead = 1'b0;
  endfunction

  function void open_char(input logic [7:0] b);
    if (b < 8'h80) begin
      code_acc   = {24'd0, b[6:0]};
      bytes_left = 3'd0;
    end else if (b < 8'hC0) begin
      code_acc   = {25'd0, b[5:0]};
      bytes_left = 3'd4;
    end else if (b < 8'hE0) begin
      code_acc   = {26'd0, b[4:0]};
      bytes_left = 3'd1;
    end else if (b < 8'hF0) begin
      code_acc   = {27'd0, b[3:0]};
      bytes_left = 3'd2;
    end else if (b < 8'hF8) begin
      code_acc   = {28'd0, b[2:0]};
      bytes_left = 3'd3;
    end else if (b < 8'hFC) begin
      code_acc   = {29'd0, b[1:0]};
      bytes_left = 3'd4;
    end else begin
      code_acc   = {30'd0, b[0]};
      bytes_left = 3'd5;
    end
    three_lead = (b[7:4] == 4'hE);
    if (bytes_left == 3'd0) flush_char();
  endfunction

  function void note_request(input logic [7:0] b, input logic str_end);
    int n0;
    n0 = expected_latin.size();
    if (bytes_left != 3'd0) begin
      if (b[7:6] == utl_pkg::CONT_TAG) begin
        code_acc   = {code_acc[24:0], b[5:0]};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 3'd0) flush_char();
      end else begin
        flush_char();
        open_char(b);
      end
    end else begin
      open_char(b);
    end
    if (str_end && bytes_left != 3'd0) flush_char();
    if (expected_latin.size() > n0) expected_latin[$].run_last = 1'b1;
  endfunction

  function void report(input string what, input latin_res_t exp_r, input latin_res_t act_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected latin_byte=%h run_last=%b, got latin_byte=%h run_last=%b",
               $realtime, what, exp_r.latin_byte, exp_r.run_last, act_r.latin_byte,
               act_r.run_last);
  endfunction

  function void check_result(input logic [7:0] latin, input logic last);
    latin_res_t act_r;
    latin_res_t exp_r;
    act_r.latin_byte = latin;
    act_r.run_last   = last;
    if (expected_latin.size() == 0) begin
      exp_r = '0;
      report("result with nothing expected", exp_r, act_r);
    end else begin
      exp_r = expected_latin.pop_front();
      if (exp_r.latin_byte !== latin || exp_r.run_last !== last)
        report("result mismatch", exp_r, act_r);
    end
  endfunction

  function int pending();
    return expected_latin.size();
  endfunction
endclass

module tb_top;
  import utl_pkg::*;

  logic clk;
  logic rst;

  utl_byte_if  utf8_chan();
  utl_cfg_if   cfg_chan();
  utl_latin_if latin_chan();

  utf8_to_latin1_transcoder_unit DUT (
    .clk(clk),
    .rst(rst),
    .utf8_chan(utf8_chan),
    .cfg_chan(cfg_chan),
    .latin_chan(latin_chan)
  );

  latin_board board = new();

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;
  int hold_reqs;
  int hold_seen;
  int hold_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && latin_chan.valid && latin_chan.ready)
      board.check_result(latin_chan.latin_byte, latin_chan.run_last);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_cnt  = 120;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      latin_chan.ready <= 1'b0;
    end else begin
      latin_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic str_end);
    while ($urandom_range(99) < send_idle_pct) begin
      utf8_chan.valid <= 1'b0;
      @(posedge clk);
    end
    utf8_chan.valid      <= 1'b1;
    utf8_chan.utf8_byte  <= b;
    utf8_chan.string_end <= str_end;
    @(posedge clk);
    while (!utf8_chan.ready) @(posedge clk);
    board.note_request(b, str_end);
    bytes_sent++;
  endtask

  // Sends the first keep bytes of a len-byte encoding of point.
  task automatic send_seq(input int len, input logic [30:0] point, input int keep);
    logic [30:0] part;
    logic [7:0]  b;
    for (int i = 0; i < keep; i++) begin
      part = point >> (6 * (len - 1 - i));
      if (i == 0) begin
        case (len)
          1: b = {1'b0, part[6:0]};
          2: b = {3'b110, part[4:0]};
          3: b = {4'b1110, part[3:0]};
          4: b = {5'b11110, part[2:0]};
          5: b = {6'b111110, part[1:0]};
          default: b = {7'b1111110, part[0]};
        endcase
      end else begin
        b = {CONT_TAG, part[5:0]};
      end
      send_byte(b, $urandom_range(15) == 0);
    end
  endtask

  task automatic send_char();
    int          kind;
    int          len;
    int          keep;
    logic [31:0] mask;
    logic [31:0] raw;
    logic [30:0] point;
    kind = $urandom_range(99);
    if (kind >= 88) begin
      if (kind < 94) begin
        repeat ($urandom_range(3, 1))
          send_byte({CONT_TAG, 6'($urandom_range(63))}, $urandom_range(15) == 0);
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end
    end else begin
      if (kind < 30) len = 1;
      else if (kind < 45) len = 2;
      else if (kind < 62) len = 3;
      else if (kind < 70) len = 4;
      else if (kind < 76) len = 5;
      else if (kind < 80) len = 6;
      else len = $urandom_range(6, 2);
      keep = (kind >= 80) ? $urandom_range(len - 1, 1) : len;
      mask = (32'h1 << (len == 1 ? 7 : 5 * len + 1)) - 32'h1;
      raw  = $urandom & mask;
      point = raw[30:0];
      if (len >= 3 && $urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: point = CP_LDQUO;
          1: point = CP_RDQUO;
          2: point = CP_RSQUO;
          default: point = CP_EURO;
        endcase
      end
      send_seq(len, point, keep);
    end
  endtask

  task automatic settle();
    utf8_chan.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_replacement(input logic [7:0] value);
    cfg_chan.valid            <= 1'b1;
    cfg_chan.replacement_byte <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    board.repl_byte = value;
  endtask

  initial begin
    int          send_idle_set[5];
    int          recv_stall_set[5];
    logic [7:0]  repl_set[5];
    int          target;
    send_idle_set  = '{0, 70, 0, 35, 0};
    recv_stall_set = '{0, 0, 70, 35, 0};
    repl_set       = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'h80, 8'($urandom_range(255))};
    rst                       = 1'b1;
    utf8_chan.valid           = 1'b0;
    utf8_chan.utf8_byte       = '0;
    utf8_chan.string_end      = 1'b0;
    cfg_chan.valid            = 1'b0;
    cfg_chan.replacement_byte = '0;
    latin_chan.ready          = 1'b0;
    send_idle_pct             = 0;
    recv_stall_pct            = 0;
    bytes_sent                = 0;
    hold_reqs                 = 0;
    hold_seen                 = 0;
    hold_cnt                  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests run with the reset replacement byte.
    send_byte(8'h00, 1'b0);
    send_seq(3, CP_LDQUO, 3);
    send_seq(3, CP_RDQUO, 3);
    send_seq(3, CP_RSQUO, 3);
    send_seq(3, CP_EURO, 3);
    // An overlong four-byte form of a quote mark must not map.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h9C, 1'b0);
    // A broken sequence yields the partial value and then the new character.
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // A sequence cut short by the end of the string.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFC, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    send_byte(8'hFF, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_replacement(repl_set[ph]);
      send_idle_pct  = send_idle_set[ph];
      recv_stall_pct = recv_stall_set[ph];
      if (ph == 0) hold_reqs++;
      target = bytes_sent + 300;
      while (bytes_sent < target) send_char();
    end
    settle();

    if (board.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/utl_pkg.sv
hw/rtl/utl_ifs.sv
hw/rtl/utl_front.sv
hw/rtl/utl_fifo.sv
hw/rtl/utl_back.sv
hw/rtl/utf8_to_latin1_transcoder_unit.sv
test/tb_top.sv
